>>> sv/rmch_pkg.sv
`default_nettype none
package rmch_pkg;

  localparam int W   = 120;
  localparam int LW  = 68;
  localparam int SW  = 33;
  localparam int N_UOP     = 24;
  localparam int MAC_STEPS = 5;
  localparam int DIV_STEPS = 32;

  localparam logic [2:0] CFG_ORG_X = 3'd0;
  localparam logic [2:0] CFG_ORG_Y = 3'd1;
  localparam logic [2:0] CFG_ORG_Z = 3'd2;
  localparam logic [2:0] CFG_DIR_X = 3'd3;
  localparam logic [2:0] CFG_DIR_Y = 3'd4;
  localparam logic [2:0] CFG_DIR_Z = 3'd5;
  localparam logic [2:0] CFG_DET_EPS = 3'd6;
  localparam logic [2:0] CFG_HIT_EPS = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_MAC, ST_NORM, ST_CHECK, ST_DIV, ST_UPDATE, ST_EMIT
  } state_e;

  typedef enum logic [3:0] {
    SH_DIR0, SH_DIR1, SH_DIR2, SH_E1_0, SH_E1_1, SH_E1_2,
    SH_E2_0, SH_E2_1, SH_E2_2, SH_S0, SH_S1, SH_S2
  } sh_sel_e;

  typedef enum logic [3:0] {
    LG_E1_0, LG_E1_1, LG_E1_2, LG_E2_0, LG_E2_1, LG_E2_2,
    LG_H0, LG_H1, LG_H2, LG_Q0, LG_Q1, LG_Q2
  } lg_sel_e;

  typedef enum logic [3:0] {
    DST_NONE, DST_H0, DST_H1, DST_H2, DST_Q0, DST_Q1, DST_Q2,
    DST_A, DST_U, DST_V, DST_T
  } dst_e;

  typedef struct packed {
    sh_sel_e sh;
    lg_sel_e lg;
    logic    sub;
    logic    first;
    dst_e    dst;
  } uop_t;

  typedef struct packed {
    logic       capture;
    logic       load;
    logic       step;
    logic       last_step;
    logic       norm;
    logic       check;
    logic       div_step;
    logic       update;
    logic       emit;
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } sts_t;

  function automatic uop_t get_uop(input logic [4:0] idx);
    uop_t u;
    u = '{sh: SH_DIR0, lg: LG_E1_0, sub: 1'b0, first: 1'b0, dst: DST_NONE};
    case (idx)
      5'd0:  u = '{SH_DIR1, LG_E2_2, 1'b0, 1'b1, DST_NONE};
      5'd1:  u = '{SH_DIR2, LG_E2_1, 1'b1, 1'b0, DST_H0};
      5'd2:  u = '{SH_DIR2, LG_E2_0, 1'b0, 1'b1, DST_NONE};
      5'd3:  u = '{SH_DIR0, LG_E2_2, 1'b1, 1'b0, DST_H1};
      5'd4:  u = '{SH_DIR0, LG_E2_1, 1'b0, 1'b1, DST_NONE};
      5'd5:  u = '{SH_DIR1, LG_E2_0, 1'b1, 1'b0, DST_H2};
      5'd6:  u = '{SH_E1_0, LG_H0, 1'b0, 1'b1, DST_NONE};
      5'd7:  u = '{SH_E1_1, LG_H1, 1'b0, 1'b0, DST_NONE};
      5'd8:  u = '{SH_E1_2, LG_H2, 1'b0, 1'b0, DST_A};
      5'd9:  u = '{SH_S1, LG_E1_2, 1'b0, 1'b1, DST_NONE};
      5'd10: u = '{SH_S2, LG_E1_1, 1'b1, 1'b0, DST_Q0};
      5'd11: u = '{SH_S2, LG_E1_0, 1'b0, 1'b1, DST_NONE};
      5'd12: u = '{SH_S0, LG_E1_2, 1'b1, 1'b0, DST_Q1};
      5'd13: u = '{SH_S0, LG_E1_1, 1'b0, 1'b1, DST_NONE};
      5'd14: u = '{SH_S1, LG_E1_0, 1'b1, 1'b0, DST_Q2};
      5'd15: u = '{SH_S0, LG_H0, 1'b0, 1'b1, DST_NONE};
      5'd16: u = '{SH_S1, LG_H1, 1'b0, 1'b0, DST_NONE};
      5'd17: u = '{SH_S2, LG_H2, 1'b0, 1'b0, DST_U};
      5'd18: u = '{SH_DIR0, LG_Q0, 1'b0, 1'b1, DST_NONE};
      5'd19: u = '{SH_DIR1, LG_Q1, 1'b0, 1'b0, DST_NONE};
      5'd20: u = '{SH_DIR2, LG_Q2, 1'b0, 1'b0, DST_V};
      5'd21: u = '{SH_E2_0, LG_Q0, 1'b0, 1'b1, DST_NONE};
      5'd22: u = '{SH_E2_1, LG_Q1, 1'b0, 1'b0, DST_NONE};
      5'd23: u = '{SH_E2_2, LG_Q2, 1'b0, 1'b0, DST_T};
      default: u = '{SH_DIR0, LG_E1_0, 1'b0, 1'b0, DST_NONE};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

>>> sv/rmch_ctrl.sv
`default_nettype none
module rmch_ctrl
  import rmch_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e     state_q, state_d;
  logic [4:0] op_q, op_d;
  logic [4:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_LOAD;
          op_d    = '0;
        end
      end
      ST_LOAD: begin
        state_d = ST_MAC;
        cnt_d   = '0;
      end
      ST_MAC: begin
        if (cnt_q == 5'(MAC_STEPS - 1)) begin
          if (op_q == 5'(N_UOP - 1)) begin
            state_d = ST_NORM;
          end else begin
            op_d    = op_q + 5'd1;
            state_d = ST_LOAD;
          end
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_NORM:  state_d = ST_CHECK;
      ST_CHECK: begin
        state_d = ST_DIV;
        cnt_d   = '0;
      end
      ST_DIV: begin
        if (cnt_q == 5'(DIV_STEPS - 1)) begin
          state_d = ST_UPDATE;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_UPDATE: state_d = sts_i.last ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = op_q;
    cmd_o.last_step = (cnt_q == 5'(MAC_STEPS - 1));
    in_ready_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_LOAD:   cmd_o.load = 1'b1;
      ST_MAC:    cmd_o.step = 1'b1;
      ST_NORM:   cmd_o.norm = 1'b1;
      ST_CHECK:  cmd_o.check = 1'b1;
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_EMIT:   cmd_o.emit = sts_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/rmch_dp.sv
`default_nettype none
module rmch_dp
  import rmch_pkg::*;
#(
  parameter int         FRAC_BITS = 16,
  parameter logic [15:0] IDX_MAX  = 16'hFFFF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [2:0][31:0] ray_org_i,
  input  wire logic [2:0][31:0] ray_dir_i,
  input  wire logic [15:0]      det_eps_i,
  input  wire logic [15:0]      hit_eps_i,
  input  wire logic [287:0]     in_data_i,
  input  wire logic             in_last_i,
  input  wire cmd_t             cmd_i,
  output sts_t                  sts_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [47:0]           out_data_o,
  output logic                  out_hit_o
);

  logic signed [SW-1:0] e1_q [3];
  logic signed [SW-1:0] e2_q [3];
  logic signed [SW-1:0] s_q  [3];
  logic signed [LW-1:0] h_q  [3];
  logic signed [LW-1:0] q_q  [3];
  logic signed [W-1:0]  a_q, u_q, v_q, t_q, acc_q, mcand_q;
  logic signed [39:0]   mplr_q;
  logic                 last_q, pass_q, sat_q;
  logic [W-1:0]         rem_q;
  logic [31:0]          num_q, quo_q;
  logic                 best_valid_q;
  logic [30:0]          best_t_q, out_t_q;
  logic [15:0]          best_idx_q, pos_q, out_idx_q;
  logic                 out_valid_q, out_hit_q;

  uop_t                 uop;
  logic signed [SW-1:0] sh_op;
  logic signed [LW-1:0] lg_op;
  logic signed [8:0]    dig;
  logic signed [W+8:0]  prod;
  logic signed [W-1:0]  mac_sum;
  logic [W-1:0]         lim, uv;
  logic                 pass_c;
  logic [W+31:0]        a_shl, num_w;
  logic [W:0]           trial;
  logic [30:0]          tval;
  logic                 hit_c;

  assign uop = get_uop(cmd_i.op);

  always_comb begin
    case (uop.sh)
      SH_DIR0: sh_op = {ray_dir_i[0][31], ray_dir_i[0]};
      SH_DIR1: sh_op = {ray_dir_i[1][31], ray_dir_i[1]};
      SH_DIR2: sh_op = {ray_dir_i[2][31], ray_dir_i[2]};
      SH_E1_0: sh_op = e1_q[0];
      SH_E1_1: sh_op = e1_q[1];
      SH_E1_2: sh_op = e1_q[2];
      SH_E2_0: sh_op = e2_q[0];
      SH_E2_1: sh_op = e2_q[1];
      SH_E2_2: sh_op = e2_q[2];
      SH_S0:   sh_op = s_q[0];
      SH_S1:   sh_op = s_q[1];
      SH_S2:   sh_op = s_q[2];
      default: sh_op = '0;
    endcase
    case (uop.lg)
      LG_E1_0: lg_op = {{(LW-SW){e1_q[0][SW-1]}}, e1_q[0]};
      LG_E1_1: lg_op = {{(LW-SW){e1_q[1][SW-1]}}, e1_q[1]};
      LG_E1_2: lg_op = {{(LW-SW){e1_q[2][SW-1]}}, e1_q[2]};
      LG_E2_0: lg_op = {{(LW-SW){e2_q[0][SW-1]}}, e2_q[0]};
      LG_E2_1: lg_op = {{(LW-SW){e2_q[1][SW-1]}}, e2_q[1]};
      LG_E2_2: lg_op = {{(LW-SW){e2_q[2][SW-1]}}, e2_q[2]};
      LG_H0:   lg_op = h_q[0];
      LG_H1:   lg_op = h_q[1];
      LG_H2:   lg_op = h_q[2];
      LG_Q0:   lg_op = q_q[0];
      LG_Q1:   lg_op = q_q[1];
      LG_Q2:   lg_op = q_q[2];
      default: lg_op = '0;
    endcase
  end

  // The multiplier operand is taken eight bits a step; the top digit carries the sign.
  assign dig     = cmd_i.last_step ? {mplr_q[7], mplr_q[7:0]} : {1'b0, mplr_q[7:0]};
  assign prod    = mcand_q * dig;
  assign mac_sum = uop.sub ? acc_q - prod[W-1:0] : acc_q + prod[W-1:0];

  assign lim    = W'(det_eps_i) << (2 * FRAC_BITS);
  assign uv     = u_q + v_q;
  assign pass_c = (a_q != '0) && (a_q >= lim) && !u_q[W-1] && (u_q <= a_q) &&
                  !v_q[W-1] && (uv <= a_q) && !t_q[W-1] && (t_q != '0);
  assign a_shl  = {32'b0, a_q} << (32 - FRAC_BITS);
  assign num_w  = {32'b0, t_q} << FRAC_BITS;

  assign trial = {rem_q, num_q[31]} - {1'b0, a_q};

  assign tval  = (sat_q || quo_q[31]) ? '1 : quo_q[30:0];
  assign hit_c = pass_q && (tval > {15'b0, hit_eps_i});

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= {in_data_i[96+32*k+31], in_data_i[96+32*k +: 32]} -
                   {in_data_i[32*k+31], in_data_i[32*k +: 32]};
        e2_q[k] <= {in_data_i[192+32*k+31], in_data_i[192+32*k +: 32]} -
                   {in_data_i[32*k+31], in_data_i[32*k +: 32]};
        s_q[k]  <= {ray_org_i[k][31], ray_org_i[k]} -
                   {in_data_i[32*k+31], in_data_i[32*k +: 32]};
      end
      last_q <= in_last_i;
    end
    if (cmd_i.load) begin
      mcand_q <= {{(W-LW){lg_op[LW-1]}}, lg_op};
      mplr_q  <= {{(40-SW){sh_op[SW-1]}}, sh_op};
      if (uop.first) begin
        acc_q <= '0;
      end
    end
    if (cmd_i.step) begin
      acc_q   <= mac_sum;
      mcand_q <= mcand_q <<< 8;
      mplr_q  <= mplr_q >>> 8;
      if (cmd_i.last_step) begin
        case (uop.dst)
          DST_H0:  h_q[0] <= mac_sum[LW-1:0];
          DST_H1:  h_q[1] <= mac_sum[LW-1:0];
          DST_H2:  h_q[2] <= mac_sum[LW-1:0];
          DST_Q0:  q_q[0] <= mac_sum[LW-1:0];
          DST_Q1:  q_q[1] <= mac_sum[LW-1:0];
          DST_Q2:  q_q[2] <= mac_sum[LW-1:0];
          DST_A:   a_q <= mac_sum;
          DST_U:   u_q <= mac_sum;
          DST_V:   v_q <= mac_sum;
          DST_T:   t_q <= mac_sum;
          default: ;
        endcase
      end
    end
    if (cmd_i.norm && a_q[W-1]) begin
      a_q <= -a_q;
      u_q <= -u_q;
      v_q <= -v_q;
      t_q <= -t_q;
    end
    if (cmd_i.check) begin
      pass_q <= pass_c;
      sat_q  <= {32'b0, t_q} >= a_shl;
      rem_q  <= num_w[W+31:32];
      num_q  <= num_w[31:0];
      quo_q  <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= trial[W] ? {rem_q[W-2:0], num_q[31]} : trial[W-1:0];
      quo_q <= {quo_q[30:0], ~trial[W]};
      num_q <= {num_q[30:0], 1'b0};
    end
    if (cmd_i.emit) begin
      out_hit_q <= best_valid_q;
      out_t_q   <= best_t_q;
      out_idx_q <= best_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q <= 1'b0;
      best_t_q     <= '0;
      best_idx_q   <= '0;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.update) begin
        if (hit_c && (!best_valid_q || (tval < best_t_q))) begin
          best_valid_q <= 1'b1;
          best_t_q     <= tval;
          best_idx_q   <= pos_q;
        end
        if (pos_q < IDX_MAX) begin
          pos_q <= pos_q + 16'd1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q  <= 1'b1;
        best_valid_q <= 1'b0;
        best_t_q     <= '0;
        best_idx_q   <= '0;
        pos_q        <= '0;
      end
    end
  end

  assign sts_o.last     = last_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_hit_o      = out_hit_q;
  assign out_data_o     = {1'b0, out_idx_q, out_t_q};

endmodule
`default_nettype wire

>>> sv/ray_mesh_closest_hit_unit.sv
// Closest hit of one ray against a stream of triangles.
// The ray origin, direction and the two thresholds are written through the
// cfg port (index 0..7); the user must write them only while the unit is
// idle, which the unit itself does not enforce. They keep their values. Each
// word on the slave stream is one triangle of nine signed Q16.16 coordinates;
// tlast marks the final triangle of a mesh. A triangle is tested with
// twenty-four multiply-accumulate operations on one shared multiplier that
// takes eight bits a cycle, then a restoring divider that produces one
// quotient bit a cycle. The unit takes no new triangle until it has finished
// the current one; on the last triangle of a mesh it also waits until the
// output register is free. Only the last triangle of a mesh produces a word
// on the master stream: hit in tuser, distance and triangle index in tdata.
// That word sits in an output register, so a stalled receiver does not hold
// up the next triangles; only a second result blocks until the first has
// been taken.
// Reset returns the ray to the origin looking along +z and clears the
// running closest hit, the triangle count and any pending result.
`default_nettype none
module ray_mesh_closest_hit_unit
  import rmch_pkg::*;
#(
  parameter int MAX_TRIANGLES = 65536,
  parameter int FRAC_BITS     = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
  input  wire logic [287:0] s_axis_tdata,
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // distance, triangle index, one zero bit
  output logic [47:0]       m_axis_tdata,
  // hit
  output logic              m_axis_tuser
);

  localparam logic [15:0] IDX_MAX =
      (MAX_TRIANGLES - 1 > 65535) ? 16'hFFFF : 16'(MAX_TRIANGLES - 1);

  logic [2:0][31:0] org_q, dir_q;
  logic [15:0]      det_eps_q, hit_eps_q;
  cmd_t             cmd;
  sts_t             sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q     <= '0;
      dir_q[0]  <= '0;
      dir_q[1]  <= '0;
      dir_q[2]  <= 32'(1) << FRAC_BITS;
      det_eps_q <= 16'd1;
      hit_eps_q <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORG_X:   org_q[0]  <= cfg_data_i;
        CFG_ORG_Y:   org_q[1]  <= cfg_data_i;
        CFG_ORG_Z:   org_q[2]  <= cfg_data_i;
        CFG_DIR_X:   dir_q[0]  <= cfg_data_i;
        CFG_DIR_Y:   dir_q[1]  <= cfg_data_i;
        CFG_DIR_Z:   dir_q[2]  <= cfg_data_i;
        CFG_DET_EPS: det_eps_q <= cfg_data_i[15:0];
        CFG_HIT_EPS: hit_eps_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  rmch_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rmch_dp #(
    .FRAC_BITS (FRAC_BITS),
    .IDX_MAX   (IDX_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ray_org_i   (org_q),
    .ray_dir_i   (dir_q),
    .det_eps_i   (det_eps_q),
    .hit_eps_i   (hit_eps_q),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_hit_o   (m_axis_tuser)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("unit ready again straight after taking a triangle");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("result without a hit carries a non-zero distance or index");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid |-> (m_axis_tdata[46:31] <= IDX_MAX))
    else $error("triangle index beyond the counter limit");

endmodule
`default_nettype wire

>>> bench/ray_mesh_closest_hit_unit_test.sv
`timescale 1ns / 100ps
module ray_mesh_closest_hit_unit_test;
  import rmch_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int DRAIN_CYCLES = 220;
  localparam int STALL_LIMIT = 40000;
  localparam logic [15:0] LAST_INDEX = 16'hFFFF;
  localparam logic signed [31:0] ONE = 32'sd65536;

  typedef logic [31:0] coords_t [9];

  typedef struct {
    logic        hit;
    logic [30:0] distance;
    logic [15:0] index;
  } closest_hit_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tuser;

  ray_mesh_closest_hit_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  logic signed [31:0] ray_org [3] = '{32'sd0, 32'sd0, 32'sd0};
  logic signed [31:0] ray_dir [3] = '{32'sd0, 32'sd0, ONE};
  logic [15:0]        det_eps = 16'd1;
  logic [15:0]        hit_eps = 16'd1;
  logic               best_valid = 1'b0;
  logic [30:0]        best_dist = '0;
  logic [15:0]        best_index = '0;
  logic [15:0]        mesh_pos = '0;

  closest_hit_t hit_queue[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  coords_t prev_tri;

  // Exact Moller-Trumbore test on 128-bit integers.
  function automatic bit triangle_hits(input coords_t c, output logic [30:0] distance);
    logic signed [127:0] p[3], e1[3], e2[3], d[3], s[3], h[3], q[3];
    logic signed [127:0] a, u, v, tt, quo, lim;
    distance = '0;
    for (int k = 0; k < 3; k++) begin
      p[k] = $signed(c[k]);
      e1[k] = $signed(c[3 + k]);
      e1[k] = e1[k] - p[k];
      e2[k] = $signed(c[6 + k]);
      e2[k] = e2[k] - p[k];
      d[k] = ray_dir[k];
      s[k] = ray_org[k];
      s[k] = s[k] - p[k];
    end
    h[0] = d[1] * e2[2] - d[2] * e2[1];
    h[1] = d[2] * e2[0] - d[0] * e2[2];
    h[2] = d[0] * e2[1] - d[1] * e2[0];
    a = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
    if (a == 0) return 1'b0;
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    u = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
    v = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    tt = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    if (a < 0) begin
      a = -a;
      u = -u;
      v = -v;
      tt = -tt;
    end
    lim = {80'd0, det_eps, 32'd0};
    if (a < lim) return 1'b0;
    if (u < 0 || u > a) return 1'b0;
    if (v < 0 || u + v > a) return 1'b0;
    if (tt <= 0) return 1'b0;
    quo = (tt <<< 16) / a;
    if (quo > 128'sh7FFF_FFFF) quo = 128'sh7FFF_FFFF;
    distance = quo[30:0];
    return distance > {15'd0, hit_eps};
  endfunction

  function automatic void track_closest(input coords_t c, input logic last);
    logic [30:0] distance;
    if (triangle_hits(c, distance)) begin
      if (!best_valid || distance < best_dist) begin
        best_valid = 1'b1;
        best_dist = distance;
        best_index = mesh_pos;
      end
    end
    if (mesh_pos < LAST_INDEX) mesh_pos++;
    if (last) begin
      hit_queue.push_back('{best_valid, best_valid ? best_dist : 31'd0,
                            best_valid ? best_index : 16'd0});
      best_valid = 1'b0;
      best_dist = '0;
      best_index = '0;
      mesh_pos = '0;
    end
  endfunction

  // Called at a falling edge; returns at a falling edge with the word taken.
  task automatic send_triangle(input coords_t c, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    for (int k = 0; k < 9; k++) s_axis_tdata[32 * k +: 32] <= c[k];
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_closest(c, last);
    prev_tri = c;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (hit_queue.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_ORG_X: ray_org[0] = data;
      CFG_ORG_Y: ray_org[1] = data;
      CFG_ORG_Z: ray_org[2] = data;
      CFG_DIR_X: ray_dir[0] = data;
      CFG_DIR_Y: ray_dir[1] = data;
      CFG_DIR_Z: ray_dir[2] = data;
      CFG_DET_EPS: det_eps = data[15:0];
      CFG_HIT_EPS: hit_eps = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic program_ray(input logic [31:0] ox, oy, oz, dx, dy, dz,
                             input logic [15:0] deps, heps);
    wait_idle();
    write_reg(CFG_ORG_X, ox);
    write_reg(CFG_ORG_Y, oy);
    write_reg(CFG_ORG_Z, oz);
    write_reg(CFG_DIR_X, dx);
    write_reg(CFG_DIR_Y, dy);
    write_reg(CFG_DIR_Z, dz);
    write_reg(CFG_DET_EPS, {16'd0, deps});
    write_reg(CFG_HIT_EPS, {16'd0, heps});
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Triangle in a plane of constant z, given in whole units and raw offsets.
  function automatic coords_t flat_triangle(input int x0, y0, x1, y1, x2, y2,
                                            input logic [31:0] z);
    coords_t c;
    c = '{x0, y0, z, x1, y1, z, x2, y2, z};
    return c;
  endfunction

  function automatic coords_t unit_triangle(input logic [31:0] z, input int shift_x);
    return flat_triangle(-ONE + shift_x, -ONE, ONE + shift_x, -ONE, shift_x, ONE, z);
  endfunction

  // Triangle around a point on the ray, so that a good share of them are hit.
  function automatic coords_t aimed_triangle(input int spread);
    coords_t c;
    longint tpar, pk;
    tpar = longint'($urandom_range(1 << 20, 0));
    for (int k = 0; k < 3; k++) begin
      pk = longint'(ray_org[k]) + ((longint'(ray_dir[k]) * tpar) >>> 16);
      for (int j = 0; j < 3; j++)
        c[3 * j + k] = 32'(pk + longint'($urandom_range(2 * spread)) - spread);
    end
    return c;
  endfunction

  function automatic coords_t noise_triangle();
    coords_t c;
    for (int k = 0; k < 9; k++) c[k] = $urandom();
    return c;
  endfunction

  task automatic test_reset_ray_geometry();
    coords_t c;
    send_triangle(unit_triangle(5 * ONE, 0), 1'b1);
    c = unit_triangle(3 * ONE, 0);
    send_triangle('{c[0], c[1], c[2], c[6], c[7], c[8], c[3], c[4], c[5]}, 1'b1);
    send_triangle(unit_triangle(2 * ONE, 3 * ONE), 1'b0);
    send_triangle(unit_triangle(-5 * ONE, 0), 1'b1);
    send_triangle(flat_triangle(0, 0, ONE, ONE, 2 * ONE, 2 * ONE, ONE), 1'b0);
    send_triangle('{-ONE, 32'd0, ONE, ONE, 32'd0, ONE, 32'd0, 32'd0, 3 * ONE}, 1'b1);
    send_triangle(unit_triangle(4 * ONE, 0), 1'b0);
    send_triangle(unit_triangle(4 * ONE, 0), 1'b0);
    send_triangle(unit_triangle(7 * ONE, 0), 1'b0);
    send_triangle(unit_triangle(2 * ONE, 0), 1'b0);
    send_triangle(unit_triangle(2 * ONE, 0), 1'b1);
    send_triangle(unit_triangle(32'd1, 0), 1'b0);
    send_triangle(unit_triangle(32'd2, 0), 1'b1);
    send_triangle(unit_triangle(32'h7FFF_FFFF, 0), 1'b1);
    send_triangle(flat_triangle(0, 0, ONE, 0, 0, ONE, 6 * ONE), 1'b1);
    send_triangle('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF}, 1'b1);
    send_triangle('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF,
                    32'h8000_0000, 32'd0, 32'd1, 32'h8000_0000}, 1'b1);
  endtask

  task automatic test_extreme_settings();
    coords_t c;
    program_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_triangle(noise_triangle(), 1'b0);
    send_triangle('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000}, 1'b1);
    program_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'd0);
    send_triangle(noise_triangle(), 1'b0);
    send_triangle('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF}, 1'b1);
    // A tiny step along z, so a far triangle saturates the distance.
    program_ray(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 16'd0, 16'd0);
    send_triangle(unit_triangle(32'h4000_0000, 0), 1'b1);
    send_triangle(flat_triangle(-1, -1, 1, -1, 0, 1, ONE), 1'b0);
    c = unit_triangle(ONE, 0);
    send_triangle('{c[0], c[1], c[2], c[0], c[1], c[2], c[6], c[7], c[8]}, 1'b1);
    program_ray(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, ONE, 16'd1, 16'd1);
    send_triangle(flat_triangle(-1, -1, 1, -1, 0, 1, ONE), 1'b1);
  endtask

  task automatic test_random_meshes(input int send_idle, input int recv_stall,
                                    input int items);
    int sent, mesh_len, spread;
    logic [15:0] deps;
    send_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    sent = 0;
    while (sent < items) begin
      deps = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(16));
      program_ray($urandom_range(1 << 23) - (1 << 22), $urandom_range(1 << 23) - (1 << 22),
                  $urandom_range(1 << 23) - (1 << 22), $urandom_range(1 << 18) - (1 << 17),
                  $urandom_range(1 << 18) - (1 << 17), $urandom_range(1 << 18) - (1 << 17),
                  deps, ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(64)));
      for (int m = 0; m < 100; m += mesh_len) begin
        mesh_len = $urandom_range(8, 1);
        for (int j = 0; j < mesh_len; j++) begin
          spread = 1 << $urandom_range(20, 4);
          if (j > 0 && $urandom_range(9) == 0) send_triangle(prev_tri, j == mesh_len - 1);
          else if ($urandom_range(9) < 8) send_triangle(aimed_triangle(spread),
                                                        j == mesh_len - 1);
          else send_triangle(noise_triangle(), j == mesh_len - 1);
        end
        sent += mesh_len;
      end
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    closest_hit_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (hit_queue.size() == 0) begin
        $display("%0t: unexpected word hit=%0d t=%0h index=%0d", $time, m_axis_tuser,
                 m_axis_tdata[30:0], m_axis_tdata[46:31]);
        errors++;
      end else begin
        want = hit_queue.pop_front();
        if (m_axis_tuser !== want.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, want.hit, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[30:0] !== want.distance) begin
          $display("%0t: distance expected %0h actual %0h", $time, want.distance,
                   m_axis_tdata[30:0]);
          errors++;
        end
        if (m_axis_tdata[46:31] !== want.index) begin
          $display("%0t: index expected %0d actual %0d", $time, want.index,
                   m_axis_tdata[46:31]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_ray_geometry();
    test_extreme_settings();
    test_random_meshes(0, 0, 500);
    test_random_meshes(82, 0, 500);
    test_random_meshes(0, 82, 500);
    test_random_meshes(21, 21, 500);
    wait_idle();
    if (errors == 0 && hit_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> ray_mesh_closest_hit_unit.f
sv/rmch_pkg.sv
sv/rmch_ctrl.sv
sv/rmch_dp.sv
sv/ray_mesh_closest_hit_unit.sv
bench/ray_mesh_closest_hit_unit_test.sv
